// ===== rtl/core/bpa_pkg.sv =====
// Package: shared constants, command/status codes and controller-datapath structs.
package bpa_pkg;

    localparam int MAX_PAGES     = 65536;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = MAX_PAGES / MAP_WORD_BITS;
    localparam int PAGE_W        = $clog2(MAX_PAGES);
    localparam int CNT_W         = PAGE_W + 1;
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int WADDR_W       = PAGE_W - BIT_W;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RUN     = 2'd1;
    localparam logic [1:0] CMD_FREE    = 2'd2;
    localparam logic [1:0] CMD_RESERVE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_DBL_FREE = 3'd3;
    localparam logic [2:0] ST_USED     = 3'd4;
    localparam logic [2:0] ST_ZERO     = 3'd5;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture input word, set up scan at the hint
        logic rd;         // issue map read at the current address
        logic chk;        // evaluate the single-page command on read data
        logic scan;       // examine the current scan page
        logic mrd;        // read the word holding the current mark page
        logic mark;       // set the current mark page used, advance
        logic finish;     // build the result word
    } bpa_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clearing;   // map clearing pass after reset still running
        logic single;     // command handled without scanning
        logic scan_done;  // scan ended (hit or past limit)
        logic scan_hit;   // scan found space
        logic mark_done;  // last page of the run marked
    } bpa_sts_t;

endpackage

// ===== rtl/core/bpa_ctrl.sv =====
// Controller: sequences map reads, scans, run marking and result hand-off.
module bpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              idle,
    input  bpa_pkg::bpa_sts_t sts,
    output bpa_pkg::bpa_cmd_t cmd
);
    import bpa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // read issued for first word
    localparam logic [2:0] S_EVAL = 3'd2;  // single command check, else on to the scan
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_MRD  = 3'd4;  // read word of the page to mark
    localparam logic [2:0] S_MARK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;

    always_comb begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        cmd          = '0;
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
        s_tready = (state_reg == S_IDLE) && !sts.clearing;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (sts.single) begin
                    cmd.chk    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                cmd.rd   = 1'b1;
                if (sts.scan_done) begin
                    state_next = sts.scan_hit ? S_MRD : S_DONE;
                end
            end
            S_MRD: begin
                cmd.mrd    = 1'b1;
                cmd.rd     = 1'b1;
                state_next = S_MARK;
            end
            S_MARK: begin
                cmd.mark = 1'b1;
                if (sts.mark_done) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MRD;
                end
            end
            S_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.finish   = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign idle     = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end
endmodule

// ===== rtl/core/bpa_dpath.sv =====
// Datapath: used map memory with a clearing pass, hint, counters and scan/mark logic.
module bpa_dpath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bpa_pkg::bpa_cmd_t          cmd,
    output bpa_pkg::bpa_sts_t          sts,
    input  logic [1:0]                 in_cmd,
    input  logic [bpa_pkg::PAGE_W-1:0] in_page,
    input  logic [bpa_pkg::CNT_W-1:0]  in_run,
    input  logic [bpa_pkg::CNT_W-1:0]  managed_pages,
    output logic [2:0]                 o_status,
    output logic [bpa_pkg::PAGE_W-1:0] o_first,
    output logic [bpa_pkg::CNT_W-1:0]  o_used,
    output logic [bpa_pkg::CNT_W-1:0]  o_free
);
    import bpa_pkg::*;

    // Map memory; a clearing pass after reset writes every word all used.
    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] rd_data_reg;
    logic                     clr_reg;
    logic [WADDR_W-1:0]       clr_addr_reg;

    logic [1:0]         cmd_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [CNT_W-1:0]   hint_reg, hint_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;     // scan position
    logic [CNT_W-1:0]   start_reg, start_next; // current free run start
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   mcnt_reg, mcnt_next;   // pages left to mark
    logic [2:0]         status_reg, status_next;
    logic [PAGE_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]   lim;

    logic [MAP_WORD_BITS-1:0] word;
    logic [MAP_WORD_BITS-1:0] wr_data;
    logic [WADDR_W-1:0]       wr_addr, rd_addr;
    logic                     wr_en;
    logic [PAGE_W-1:0]        cur_page;
    logic [PAGE_W-1:0]        pos_inc;
    logic                     cur_used;
    logic                     single;
    logic                     scan_in_range;
    logic [CNT_W-1:0]         len_inc;

    assign lim  = (managed_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : managed_pages;
    assign word = rd_data_reg;

    // Single-page commands: free, reserve, and zero-length run.
    assign single = (cmd_reg == CMD_FREE) || (cmd_reg == CMD_RESERVE)
                 || ((cmd_reg == CMD_RUN) && (run_reg == '0));

    // Page examined this cycle: page operand, scan position or mark position.
    always_comb begin
        if (single) begin
            cur_page = page_reg;
        end else if (cmd.mark || cmd.mrd) begin
            cur_page = start_reg[PAGE_W-1:0];
        end else begin
            cur_page = pos_reg[PAGE_W-1:0];
        end
    end
    assign cur_used      = word[cur_page[BIT_W-1:0]];
    assign scan_in_range = (pos_reg < lim);
    assign len_inc       = len_reg + CNT_W'(1);
    assign pos_inc       = pos_reg[PAGE_W-1:0] + PAGE_W'(1);

    // Read address: next scan position when scanning, else current page.
    always_comb begin
        if (cmd.scan) begin
            rd_addr = pos_inc[PAGE_W-1:BIT_W];
        end else begin
            rd_addr = cur_page[PAGE_W-1:BIT_W];
        end
    end

    // Main sequencing.
    always_comb begin
        hint_next    = hint_reg;
        free_next    = free_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        mcnt_next    = mcnt_reg;
        status_next  = status_reg;
        first_next   = first_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_page[PAGE_W-1:BIT_W];
        wr_data      = word;
        sts          = '0;
        sts.clearing = clr_reg;
        sts.single   = single;
        if (cmd.load) begin
            pos_next    = hint_reg;
            len_next    = '0;
            status_next = ST_OK;
            first_next  = '0;
        end
        if (cmd.chk) begin
            case (cmd_reg)
                CMD_FREE: begin
                    if (page_reg == '0 || {1'b0, page_reg} >= lim) begin
                        status_next = ST_RANGE;
                    end else if (!cur_used) begin
                        status_next = ST_DBL_FREE;
                    end else begin
                        wr_en     = 1'b1;
                        wr_data   = word & ~(MAP_WORD_BITS'(1) << page_reg[BIT_W-1:0]);
                        free_next = free_reg + CNT_W'(1);
                        if ({1'b0, page_reg} < hint_reg) begin
                            hint_next = {1'b0, page_reg};
                        end
                    end
                end
                CMD_RESERVE: begin
                    if ({1'b0, page_reg} >= lim) begin
                        status_next = ST_RANGE;
                    end else if (cur_used) begin
                        status_next = ST_USED;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = word | (MAP_WORD_BITS'(1) << page_reg[BIT_W-1:0]);
                        if (free_reg != '0) begin
                            free_next = free_reg - CNT_W'(1);
                        end
                        if ({1'b0, page_reg} == hint_reg) begin
                            hint_next = hint_reg + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    status_next = ST_ZERO;
                end
            endcase
        end
        if (cmd.scan) begin
            if (!scan_in_range) begin
                sts.scan_done = 1'b1;
                status_next   = ST_NO_SPACE;
            end else if (cur_used) begin
                len_next = '0;
                pos_next = pos_reg + CNT_W'(1);
            end else begin
                if (len_reg == '0) begin
                    start_next = pos_reg;
                end
                len_next = len_inc;
                pos_next = pos_reg + CNT_W'(1);
                if ((cmd_reg == CMD_ALLOC) || (len_inc == run_reg)) begin
                    sts.scan_done = 1'b1;
                    sts.scan_hit  = 1'b1;
                    mcnt_next     = len_inc;
                    if (len_reg == '0) begin
                        first_next = pos_reg[PAGE_W-1:0];
                    end else begin
                        first_next = start_reg[PAGE_W-1:0];
                        start_next = start_reg;
                    end
                    if (cmd_reg == CMD_ALLOC || run_reg == CNT_W'(1)) begin
                        hint_next = pos_reg + CNT_W'(1);
                    end
                    // free count is clamped at zero
                    free_next = (free_reg >= len_inc) ? free_reg - len_inc : '0;
                    if (len_reg == '0) begin
                        start_next = pos_reg;
                    end
                end
            end
        end
        if (cmd.mark) begin
            wr_en      = 1'b1;
            wr_data    = word | (MAP_WORD_BITS'(1) << start_reg[BIT_W-1:0]);
            start_next = start_reg + CNT_W'(1);
            mcnt_next  = mcnt_reg - CNT_W'(1);
            if (mcnt_reg == CNT_W'(1)) begin
                sts.mark_done = 1'b1;
            end
        end
    end

    // Map: one read and one write port; read data registered, held when not read.
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            map_mem[clr_addr_reg] <= '1;
        end else if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Clearing pass: one map word per cycle after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_reg) begin
            clr_addr_reg <= clr_addr_reg + WADDR_W'(1);
            if (clr_addr_reg == '1) begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg <= CNT_W'(1);
            free_reg <= '0;
        end else begin
            hint_reg <= hint_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd.load ? in_cmd  : cmd_reg;
        page_reg    <= cmd.load ? in_page : page_reg;
        run_reg     <= cmd.load ? in_run  : run_reg;
        pos_reg     <= pos_next;
        start_reg   <= start_next;
        len_reg     <= len_next;
        mcnt_reg    <= mcnt_next;
        status_reg  <= status_next;
        first_reg   <= first_next;
    end

    // Result word fields, captured at finish.
    logic [2:0]        res_status_reg;
    logic [PAGE_W-1:0] res_first_reg;
    logic [CNT_W-1:0]  res_used_reg, res_free_reg;
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_status_reg <= status_reg;
            res_first_reg  <= (status_reg == ST_OK) ? first_reg : '0;
            res_used_reg   <= (lim > free_reg) ? lim - free_reg : '0;
            res_free_reg   <= free_reg;
        end
    end
    assign o_status = res_status_reg;
    assign o_first  = res_first_reg;
    assign o_used   = res_used_reg;
    assign o_free   = res_free_reg;
endmodule

// ===== rtl/core/bitmap_page_allocator.sv =====
// Top level: bitmap page allocator with streaming command and result channels.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    tuser: cmd[1:0]
//                                        tdata: page_number[15:0] run_length[32:16]
//  m_        out  m_tvalid / m_tready    tdata: status, first_page, used_pages, free_pages
//  cfg_      in   cfg_valid / cfg_ready  managed_pages[16:0]
//
// One word at a time. Free, reserve and zero runs step from one accept to the next
// through load, read, check and result. Allocations step through load, read and
// evaluate, a scan step per page examined from the hint (and a last one when the scan
// runs past the limit), a read and a write per page marked, then result. m_tvalid
// rises the cycle after the result step. Reset is synchronous, active low; a clearing
// pass then sets all 1024 map words to all used, and s_tready stays low until it ends.
// A stalled result holds in its output register; the next word is still accepted
// and processed, and waits in the result step until the register frees up.
module bitmap_page_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic [39:0] s_tdata,   // page_number[15:0], run_length[32:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], first_page[18:3], used[35:19], free[52:36]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    import bpa_pkg::*;

    logic [CNT_W-1:0] managed_reg;
    bpa_cmd_t         cmd;
    bpa_sts_t         sts;
    logic             ctrl_idle;
    logic [2:0]        o_status;
    logic [PAGE_W-1:0] o_first;
    logic [CNT_W-1:0]  o_used, o_free;

    // Accept a size write only while no command is in flight.
    assign cfg_ready = ctrl_idle;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            managed_reg <= CNT_W'(MAX_PAGES);
        end else if (cfg_valid && cfg_ready) begin
            managed_reg <= cfg_data;
        end
    end

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .idle     (ctrl_idle),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpa_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_cmd        (s_tuser),
        .in_page       (s_tdata[15:0]),
        .in_run        (s_tdata[32:16]),
        .managed_pages (managed_reg),
        .o_status      (o_status),
        .o_first       (o_first),
        .o_used        (o_used),
        .o_free        (o_free)
    );

    // Pad result to whole bytes.
    assign m_tdata = {3'b000, o_free, o_used, o_first, o_status};
endmodule
